FILE: src/oaht_pkg.sv
// Package for the open-address string hash table.
// Holds default sizes, status codes, the sequencer state type and hash and probe constants.
`timescale 1ns / 1ps
package oaht_pkg;
  localparam int unsigned DefSlots    = 101;
  localparam int unsigned DefProbes   = 20;
  localparam int unsigned DefMaxChars = 16;
  localparam int unsigned HashMul     = 19;
  localparam int unsigned ProbeStep   = 23;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_TOOLONG  = 3'd5;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DEL = 1'b1;

  typedef enum logic [2:0] {
    S_RECV, S_HMUL, S_HADD, S_LOOK_RD, S_LOOK_CHK, S_INS_CHK, S_WRITE, S_OUT
  } oaht_state_t;
endpackage

FILE: src/oaht_if.sv
// Valid/ready channel interfaces for the hash table.
// Depends on nothing.
`timescale 1ns / 1ps
interface oaht_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] key_char;
  logic       key_last;
  modport source (output valid, cmd, key_char, key_last, input ready);
  modport sink   (input valid, cmd, key_char, key_last, output ready);
endinterface

interface oaht_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] slot;
  logic [6:0] entry_count;
  modport source (output valid, status, slot, entry_count, input ready);
  modport sink   (input valid, status, slot, entry_count, output ready);
endinterface

FILE: src/open_address_string_hash_table.sv
// Open-address string hash table, top level; uses oaht_pkg, oaht_if and oaht_mod_add.
// Each stored character beat passes accept, reciprocal reduction and shared-adder accumulate.
// After the last character: lookup probes (read, then check), free-slot probes on add, write if needed, output;
// the result beat is held while the output stalls, and one beat is handled at a time.
// Synchronous active-low reset clears live/tombstone bits, count and key state;
// key storage is a memory that needs no clearing.
`timescale 1ns / 1ps
module open_address_string_hash_table
  import oaht_pkg::*;
#(
  parameter int unsigned TableSlots  = DefSlots,
  parameter int unsigned ProbeLimit  = DefProbes,
  parameter int unsigned MaxKeyChars = DefMaxChars
) (
  input logic clk,
  input logic rst_n,
  oaht_in_if.sink    in_ch,
  oaht_out_if.source out_ch
);
  localparam int unsigned SW = $clog2(TableSlots);
  localparam int unsigned PW = $clog2(MaxKeyChars + 2);
  localparam int unsigned JW = $clog2(ProbeLimit + 1);
  localparam int unsigned KB = MaxKeyChars * 8;
  localparam int unsigned KIW = (MaxKeyChars > 1) ? $clog2(MaxKeyChars) : 1;
  // character product and its reciprocal reduction
  localparam int unsigned PB  = 8 + SW;
  localparam int unsigned RK  = PB + SW;
  localparam int unsigned RMW = RK - SW + 2;
  localparam int unsigned PRW = PB + RMW;
  localparam longint unsigned RecipMul =
    ((64'd1 << RK) + 64'(TableSlots) - 64'd1) / 64'(TableSlots);
  localparam logic [SW-1:0] HashStep  = SW'(HashMul % TableSlots);
  localparam logic [SW-1:0] DeltaInit = SW'((ProbeStep + 1) % TableSlots);

  oaht_state_t state_r, state_nxt;

  logic [7:0]      kbuf_r [MaxKeyChars];
  logic [PW-1:0]   pos_r;
  logic [SW-1:0]   hash_r;
  logic [SW-1:0]   w_r;        // 19*(pos+1) mod slots
  logic [PB-1:0]   p_r;
  logic [7:0]      q_r;
  logic            last_r;
  logic            cmd_r;
  logic [SW-1:0]   home_r;
  logic [PW-1:0]   len_r;
  logic [JW-1:0]   j_r;
  logic [SW-1:0]   off_r;      // j*j + 23j mod slots
  logic [SW-1:0]   dlt_r;      // (2j + 24) mod slots, next increment
  logic [SW-1:0]   cur_r;
  logic [TableSlots-1:0] live_r, tomb_r;
  logic [6:0]      cnt_r;
  logic [2:0]      status_r;
  logic [6:0]      oslot_r;

  logic [KB-1:0]   mem_key [TableSlots];
  logic [PW-1:0]   mem_len [TableSlots];
  logic [KB-1:0]   rd_key_r;
  logic [PW-1:0]   rd_len_r;
  logic [KB-1:0]   kflat;

  always_comb begin
    kflat = '0;
    for (int i = 0; i < MaxKeyChars; i++) begin
      if (PW'(i) < len_r) kflat[i*8 +: 8] = kbuf_r[i];
    end
  end

  logic [PRW-1:0] rcp_prod;
  assign rcp_prod = PRW'(p_r) * PRW'(RMW'(RecipMul));

  logic [PB-1:0] qd;
  logic [SW-1:0] rem;
  assign qd  = PB'(q_r) * PB'(TableSlots);
  assign rem = SW'(p_r - qd);

  // Shared modular adder: weight step, hash accumulate and offset update.
  logic [SW-1:0] ma_a, ma_b, ma_y;
  oaht_mod_add #(.Slots(TableSlots)) u_add (.a(ma_a), .b(ma_b), .y(ma_y));

  always_comb begin
    ma_a = off_r;
    ma_b = dlt_r;
    case (state_r)
      S_HMUL: begin
        ma_a = w_r;
        ma_b = HashStep;
      end
      S_HADD: begin
        ma_a = hash_r;
        ma_b = rem;
      end
      default: ;
    endcase
  end

  logic [SW:0]   dlt_sum;
  logic [SW-1:0] dlt_inc;
  assign dlt_sum = {1'b0, dlt_r} + (SW+1)'(2);
  assign dlt_inc = (dlt_sum >= (SW+1)'(TableSlots)) ?
                   SW'(dlt_sum - (SW+1)'(TableSlots)) : dlt_sum[SW-1:0];

  logic [SW-1:0] cur_nxt;
  assign cur_nxt = (home_r + ma_y >= TableSlots) ?
                   SW'(home_r + ma_y - SW'(TableSlots)) : SW'(home_r + ma_y);

  logic hit, empty_s;
  assign hit     = live_r[cur_r] && rd_len_r == len_r && rd_key_r == kflat;
  assign empty_s = !live_r[cur_r] && !tomb_r[cur_r];

  logic last_probe;
  assign last_probe = (j_r == JW'(ProbeLimit - 1));

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_RECV);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = status_r;
  assign out_ch.slot = oslot_r;
  assign out_ch.entry_count = cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RECV: if (in_acc) begin
        if (pos_r < PW'(MaxKeyChars)) state_nxt = S_HMUL;
        else if (in_ch.key_last) state_nxt = S_OUT;
      end
      S_HMUL:     state_nxt = S_HADD;
      S_HADD:     state_nxt = last_r ? S_LOOK_RD : S_RECV;
      S_LOOK_RD:  state_nxt = S_LOOK_CHK;
      S_LOOK_CHK: begin
        if (hit) state_nxt = (cmd_r == CMD_DEL) ? S_WRITE : S_OUT;
        else if (empty_s || last_probe) state_nxt = (cmd_r == CMD_ADD) ? S_INS_CHK : S_OUT;
        else state_nxt = S_LOOK_RD;
      end
      S_INS_CHK: begin
        if (!live_r[cur_r]) state_nxt = S_WRITE;
        else if (last_probe) state_nxt = S_OUT;
      end
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_RECV;
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RECV;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hash_r <= '0;
      w_r    <= HashStep;
      live_r <= '0;
      tomb_r <= '0;
      cnt_r  <= '0;
    end else begin
      unique case (state_r)
        S_RECV: if (in_acc) begin
          cmd_r  <= in_ch.cmd;
          last_r <= in_ch.key_last;
          if (pos_r < PW'(MaxKeyChars)) begin
            kbuf_r[pos_r[KIW-1:0]] <= in_ch.key_char;
            p_r   <= PB'(in_ch.key_char) * PB'(w_r);
            pos_r <= pos_r + PW'(1);
          end else if (in_ch.key_last) begin
            pos_r    <= '0;
            hash_r   <= '0;
            w_r      <= HashStep;
            status_r <= ST_TOOLONG;
            oslot_r  <= '0;
          end else begin
            pos_r <= PW'(MaxKeyChars + 1);
          end
        end
        S_HMUL: begin
          q_r <= rcp_prod[RK +: 8];
          w_r <= ma_y;
        end
        S_HADD: begin
          if (last_r) begin
            pos_r    <= '0;
            hash_r   <= '0;
            w_r      <= HashStep;
            len_r    <= pos_r;
            home_r   <= ma_y;
            cur_r    <= ma_y;
            j_r      <= '0;
            off_r    <= '0;
            dlt_r    <= DeltaInit;
            status_r <= ST_TOOLONG;
            oslot_r  <= '0;
          end else begin
            hash_r <= ma_y;
          end
        end
        S_LOOK_RD: begin
          rd_key_r <= mem_key[cur_r];
          rd_len_r <= mem_len[cur_r];
        end
        S_LOOK_CHK: begin
          if (hit) begin
            oslot_r  <= 7'(cur_r);
            status_r <= (cmd_r == CMD_DEL) ? ST_DELETED : ST_PRESENT;
          end else if (empty_s || last_probe) begin
            status_r <= (cmd_r == CMD_DEL) ? ST_NOTFOUND : ST_FULL;
            j_r   <= '0;
            off_r <= '0;
            dlt_r <= DeltaInit;
            cur_r <= home_r;
          end else begin
            j_r   <= j_r + JW'(1);
            off_r <= ma_y;
            dlt_r <= dlt_inc;
            cur_r <= cur_nxt;
          end
        end
        S_INS_CHK: begin
          if (!live_r[cur_r]) begin
            status_r <= ST_ADDED;
            oslot_r  <= 7'(cur_r);
          end else begin
            j_r   <= j_r + JW'(1);
            off_r <= ma_y;
            dlt_r <= dlt_inc;
            cur_r <= cur_nxt;
          end
        end
        S_WRITE: begin
          if (status_r == ST_ADDED) begin
            live_r[cur_r] <= 1'b1;
            tomb_r[cur_r] <= 1'b0;
            cnt_r <= cnt_r + 7'd1;
          end else begin
            live_r[cur_r] <= 1'b0;
            tomb_r[cur_r] <= 1'b1;
            cnt_r <= cnt_r - 7'd1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && status_r == ST_ADDED) begin
      mem_key[cur_r] <= kflat;
      mem_len[cur_r] <= len_r;
    end
  end
endmodule

FILE: src/oaht_mod_add.sv
// Modular adder: (a + b) mod M for a, b already below M.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_mod_add
  import oaht_pkg::*;
#(
  parameter int unsigned Slots = DefSlots,
  localparam int unsigned SW = $clog2(Slots)
) (
  input  logic [SW-1:0] a,
  input  logic [SW-1:0] b,
  output logic [SW-1:0] y
);
  logic [SW:0] sum;
  assign sum = {1'b0, a} + {1'b0, b};
  assign y = (sum >= (SW+1)'(Slots)) ? SW'(sum - (SW+1)'(Slots)) : sum[SW-1:0];
endmodule
